// File: rtl/dcd_pkg.sv
`default_nettype none

package dcd_pkg;

    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;

    localparam logic [YEAR_W-1:0]  EPOCH_YEAR = 12'd1978;
    localparam logic [8:0]         EPOCH_Y400 = 9'd378;
    localparam logic [6:0]         EPOCH_Y100 = 7'd78;
    localparam logic [8:0]         LAST_Y400  = 9'd399;
    localparam logic [6:0]         LAST_Y100  = 7'd99;
    localparam logic [17:0]        DAYS_400   = 18'd146097;
    localparam logic [YEAR_W-1:0]  YEAR_SPAN  = 12'd400;
    localparam logic [8:0]         DAYS_LEAP  = 9'd366;
    localparam logic [8:0]         DAYS_PLAIN = 9'd365;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd11;

    typedef struct packed {
        logic load;
        logic div_step;
        logic year_step;
        logic month_step;
        logic emit;
    } dcd_cmd_t;

    typedef struct packed {
        logic year_ge;
        logic month_stop;
    } dcd_status_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (month) inside
            MONTH_FEB:            len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default:              len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// File: rtl/dcd_datapath.sv
`default_nettype none

module dcd_datapath #(
    parameter int DAY_COUNT_BITS = 16,
    parameter int KW             = 1
) (
    input  wire logic                        aclk,
    input  wire dcd_pkg::dcd_cmd_t           cmd,
    input  wire logic [KW-1:0]               div_k,
    output dcd_pkg::dcd_status_t             status,
    input  wire logic [DAY_COUNT_BITS-1:0]   s_day_count,
    output logic [dcd_pkg::YEAR_W-1:0]       m_year,
    output logic [dcd_pkg::MONTH_W-1:0]      m_month,
    output logic [dcd_pkg::DAY_W-1:0]        m_day_of_month
);
    import dcd_pkg::*;

    localparam int W = (DAY_COUNT_BITS > 18) ? DAY_COUNT_BITS : 18;

    logic [DAY_COUNT_BITS-1:0] rem_reg, rem_next;
    logic [YEAR_W-1:0]         year_reg, year_next;
    logic [8:0]                y400_reg, y400_next;
    logic [6:0]                y100_reg, y100_next;
    logic [MONTH_W-1:0]        month_reg, month_next;
    logic [YEAR_W-1:0]         out_year_reg;
    logic [MONTH_W-1:0]        out_month_reg;
    logic [DAY_W-1:0]          out_day_reg;

    logic                      leap;
    logic [8:0]                ylen;
    logic [DAY_W-1:0]          mlen;
    logic [W-1:0]              span;
    logic                      span_ge;

    always_comb begin
        leap    = (y100_reg == '0) ? (y400_reg == '0) : (y400_reg[1:0] == 2'b00);
        ylen    = leap ? DAYS_LEAP : DAYS_PLAIN;
        mlen    = month_len(month_reg, leap);
        span    = W'(DAYS_400) << div_k;
        span_ge = W'(rem_reg) >= span;
        status.year_ge    = rem_reg >= DAY_COUNT_BITS'(ylen);
        status.month_stop = (rem_reg < DAY_COUNT_BITS'(mlen)) || (month_reg == MONTH_LAST);
    end

    always_comb begin
        rem_next   = rem_reg;
        year_next  = year_reg;
        y400_next  = y400_reg;
        y100_next  = y100_reg;
        month_next = month_reg;
        if (cmd.load) begin
            rem_next   = s_day_count;
            year_next  = EPOCH_YEAR;
            y400_next  = EPOCH_Y400;
            y100_next  = EPOCH_Y100;
            month_next = '0;
        end else if (cmd.div_step) begin
            if (span_ge) begin
                rem_next  = DAY_COUNT_BITS'(W'(rem_reg) - span);
                year_next = year_reg + (YEAR_SPAN << div_k);
            end
        end else if (cmd.year_step) begin
            rem_next  = rem_reg - DAY_COUNT_BITS'(ylen);
            year_next = year_reg + 1'b1;
            y400_next = (y400_reg == LAST_Y400) ? '0 : y400_reg + 1'b1;
            y100_next = (y100_reg == LAST_Y100) ? '0 : y100_reg + 1'b1;
        end else if (cmd.month_step) begin
            rem_next   = rem_reg - DAY_COUNT_BITS'(mlen);
            month_next = month_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        year_reg  <= year_next;
        y400_reg  <= y400_next;
        y100_reg  <= y100_next;
        month_reg <= month_next;
        if (cmd.emit) begin
            out_year_reg  <= year_reg;
            out_month_reg <= month_reg + 1'b1;
            out_day_reg   <= rem_reg[DAY_W-1:0] + 1'b1;
        end
    end

    assign m_year         = out_year_reg;
    assign m_month        = out_month_reg;
    assign m_day_of_month = out_day_reg;

endmodule

`default_nettype wire

// File: rtl/dcd_controller.sv
`default_nettype none

module dcd_controller #(
    parameter int QBITS = 1,
    parameter int KW    = 1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output dcd_pkg::dcd_cmd_t         cmd,
    output logic [KW-1:0]             div_k,
    input  wire dcd_pkg::dcd_status_t status
);
    import dcd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_YEAR,
        ST_MONTH,
        ST_FINISH
    } state_t;

    state_t        state_reg, state_next;
    logic [KW-1:0] k_reg, k_next;
    logic          m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    k_next     = KW'(QBITS - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (k_reg == '0) begin
                    state_next = ST_YEAR;
                end else begin
                    k_next = k_reg - 1'b1;
                end
            end
            ST_YEAR: begin
                if (status.year_ge) begin
                    cmd.year_step = 1'b1;
                end else begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH: begin
                if (status.month_stop) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.month_step = 1'b1;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.emit     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign div_k   = k_reg;

endmodule

`default_nettype wire

// File: rtl/day_count_to_calendar_date_unit.sv
`default_nettype none

// Channel   Ports                                     Direction
// input     s_valid, s_ready, s_day_count             day count in
// result    m_valid, m_ready, m_year, m_month,        calendar date out
//           m_day_of_month
//
// One transfer in gives one transfer out. An item is loaded, then goes
// through the 146097-day division one quotient bit per step (one bit for
// counts of up to 18 bits), then subtracts one year per step while the
// days left reach that year's length, then one month per step until they
// fall short of that month's length or December is reached, and finishes.
// The result sits in an output register, so the next item is taken while it
// waits; a stalled result only holds the finish step. Reset is synchronous.

module day_count_to_calendar_date_unit #(
    parameter int DAY_COUNT_BITS = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [DAY_COUNT_BITS-1:0] s_day_count,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [dcd_pkg::YEAR_W-1:0]     m_year,
    output logic [dcd_pkg::MONTH_W-1:0]    m_month,
    output logic [dcd_pkg::DAY_W-1:0]      m_day_of_month
);
    import dcd_pkg::*;

    localparam int QBITS = (DAY_COUNT_BITS > 18) ? (DAY_COUNT_BITS - 17) : 1;
    localparam int KW    = (QBITS > 1) ? $clog2(QBITS) : 1;

    dcd_cmd_t      cmd;
    dcd_status_t   status;
    logic [KW-1:0] div_k;

    dcd_controller #(
        .QBITS (QBITS),
        .KW    (KW)
    ) u_controller (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .div_k   (div_k),
        .status  (status)
    );

    dcd_datapath #(
        .DAY_COUNT_BITS (DAY_COUNT_BITS),
        .KW             (KW)
    ) u_datapath (
        .aclk           (aclk),
        .cmd            (cmd),
        .div_k          (div_k),
        .status         (status),
        .s_day_count    (s_day_count),
        .m_year         (m_year),
        .m_month        (m_month),
        .m_day_of_month (m_day_of_month)
    );

endmodule

`default_nettype wire
